// ===== src/jsu_pkg.sv =====
package jsu_pkg;

  // Input word fields are fixed at 32 bits; the datapath may be up to 64.
  localparam int unsigned InWidth  = 32;
  localparam int unsigned ExtWidth = 64;

  localparam logic [1:0] SymZero = 2'b00;
  localparam logic [1:0] SymPos  = 2'b01;
  localparam logic [1:0] SymNeg  = 2'b11;

  typedef struct packed {
    logic load;     // take a new operand pair
    logic step;     // one reduction step
    logic capture;  // move the finished symbol into the output register
  } jsu_cmd_t;

  typedef struct packed {
    logic done;     // working value reached zero
  } jsu_stat_t;

endpackage

// ===== src/jsu_ctrl.sv =====
module jsu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  jsu_pkg::jsu_stat_t stat_i,
  output jsu_pkg::jsu_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load    = in_valid_i && (state_q == StIdle);
    cmd_o.step    = (state_q == StRun) && !stat_i.done;
    // result slot is free, or is being drained this cycle
    cmd_o.capture = (state_q == StRun) && stat_i.done && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.load) state_d = StRun;
      end
      StRun: begin
        if (cmd_o.capture) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/jsu_datapath.sv =====
module jsu_datapath #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic [jsu_pkg::InWidth-1:0]       value_i,
  input  logic [jsu_pkg::InWidth-1:0]       modulus_i,
  input  jsu_pkg::jsu_cmd_t                 cmd_i,
  output jsu_pkg::jsu_stat_t                stat_o,
  output logic signed [1:0]                 symbol_o,
  output logic                              bad_modulus_o
);

  logic [jsu_pkg::ExtWidth-1:0] value_ext, modulus_ext;
  logic [WIDTH-1:0] a_q, a_d, n_q, n_d;
  logic             neg_q, neg_d;
  logic             bad_q, bad_d;
  logic [1:0]       sym_q, sym_d;
  logic             obad_q;

  assign value_ext   = {{(jsu_pkg::ExtWidth - jsu_pkg::InWidth){1'b0}}, value_i};
  assign modulus_ext = {{(jsu_pkg::ExtWidth - jsu_pkg::InWidth){1'b0}}, modulus_i};

  assign stat_o.done = (a_q == '0);

  // Binary Jacobi: halve even values, swap with reciprocity when a < n,
  // otherwise subtract n (both odd, so the difference is even).
  always_comb begin
    a_d   = a_q;
    n_d   = n_q;
    neg_d = neg_q;
    bad_d = bad_q;
    if (cmd_i.load) begin
      n_d   = modulus_ext[WIDTH-1:0];
      bad_d = !modulus_ext[0];
      // an even or zero modulus ends at once
      a_d   = modulus_ext[0] ? value_ext[WIDTH-1:0] : '0;
      neg_d = 1'b0;
    end else if (cmd_i.step) begin
      if (!a_q[0]) begin
        a_d = a_q >> 1;
        if (n_q[2:0] == 3'd3 || n_q[2:0] == 3'd5) neg_d = !neg_q;
      end else if (a_q < n_q) begin
        a_d = n_q;
        n_d = a_q;
        if (a_q[1:0] == 2'd3 && n_q[1:0] == 2'd3) neg_d = !neg_q;
      end else begin
        a_d = a_q - n_q;
      end
    end
  end

  always_comb begin
    if (bad_q || n_q != WIDTH'(1)) begin
      sym_d = jsu_pkg::SymZero;
    end else begin
      sym_d = neg_q ? jsu_pkg::SymNeg : jsu_pkg::SymPos;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    n_q   <= n_d;
    neg_q <= neg_d;
    bad_q <= bad_d;
    if (cmd_i.capture) begin
      sym_q  <= sym_d;
      obad_q <= bad_q;
    end
  end

  assign symbol_o      = sym_q;
  assign bad_modulus_o = obad_q;

endmodule

// ===== src/jacobi_symbol_unit.sv =====
// Jacobi symbol of value over an odd modulus, binary (shift/subtract) method.
// Sequence: load the word, then one halve, swap or subtract per cycle in a single
// WIDTH-bit subtract/compare unit until the value is zero, then capture the symbol.
// Throughput: one word at a time; the next word is taken as soon as the result
// moves to the output register. Reset clears the controller and output valid.
module jacobi_symbol_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [jsu_pkg::InWidth-1:0] value_i,
  input  logic [jsu_pkg::InWidth-1:0] modulus_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [1:0]           symbol_o,
  output logic                        bad_modulus_o
);

  jsu_pkg::jsu_cmd_t  cmd;
  jsu_pkg::jsu_stat_t stat;

  jsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  jsu_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .value_i       (value_i),
    .modulus_i     (modulus_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .symbol_o      (symbol_o),
    .bad_modulus_o (bad_modulus_o)
  );

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_modulus_o |-> symbol_o == 2'sb00)
    else $error("bad modulus with nonzero symbol");

  a_sym_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> symbol_o != 2'sb10)
    else $error("illegal symbol code");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted word while busy");

endmodule
